// ===== sv/dbd_pkg.sv =====
// Shared types, constants and calendar functions for the days-between-dates counter.
// Used by dbd_step and days_between_dates_counter; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package dbd_pkg;

    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int COUNT_W = 22;
    localparam int R400_W  = 9;

    // Field order puts the year in the top bits so that a plain vector compare
    // orders two dates.
    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
    } date_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD_START,
        ST_MOD_END,
        ST_CHECK,
        ST_WALK,
        ST_FINISH
    } state_t;

    localparam logic [YEAR_W-1:0]  YEAR_CYCLE = 14'd400;
    localparam logic [R400_W-1:0]  R400_LAST  = 9'd399;
    localparam logic [R400_W-1:0]  CENT_1     = 9'd100;
    localparam logic [R400_W-1:0]  CENT_2     = 9'd200;
    localparam logic [R400_W-1:0]  CENT_3     = 9'd300;
    localparam logic [COUNT_W-1:0] COUNT_MAX  = 22'h3FFFFF;

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_MAR = 4'd3;
    localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
    localparam logic [MONTH_W-1:0] MONTH_MAY = 4'd5;
    localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
    localparam logic [MONTH_W-1:0] MONTH_JUL = 4'd7;
    localparam logic [MONTH_W-1:0] MONTH_AUG = 4'd8;
    localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
    localparam logic [MONTH_W-1:0] MONTH_OCT = 4'd10;
    localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    localparam logic [DAY_W-1:0] LEN_28 = 5'd28;
    localparam logic [DAY_W-1:0] LEN_29 = 5'd29;
    localparam logic [DAY_W-1:0] LEN_30 = 5'd30;
    localparam logic [DAY_W-1:0] LEN_31 = 5'd31;

    // Leap test on the year reduced modulo 400. Since 400 is a multiple of 4,
    // the low two bits are those of the year itself.
    function automatic logic is_leap(input logic [R400_W-1:0] r400);
        logic leap;
        begin
            leap = (r400[1:0] == 2'b00) && (r400 != CENT_1) && (r400 != CENT_2)
                && (r400 != CENT_3);
            return leap;
        end
    endfunction

    // Days in a month; zero for a month code that names no month.
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        begin
            unique case (m)
                MONTH_JAN, MONTH_MAR, MONTH_MAY, MONTH_JUL,
                MONTH_AUG, MONTH_OCT, MONTH_DEC: len = LEN_31;
                MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = LEN_30;
                MONTH_FEB: len = leap ? LEN_29 : LEN_28;
                default: len = '0;
            endcase
            return len;
        end
    endfunction

endpackage

`default_nettype wire

// ===== sv/dbd_step.sv =====
// One-day advance of a valid Gregorian date with month and year rollover.
// Depends on dbd_pkg for the date type and the month-length function.
`timescale 1ns / 1ps
`default_nettype none

module dbd_step (
    input  dbd_pkg::date_t                 cur,
    input  logic [dbd_pkg::R400_W-1:0]     cur_r400,
    output dbd_pkg::date_t                 nxt,
    output logic [dbd_pkg::R400_W-1:0]     nxt_r400
);

    logic [dbd_pkg::DAY_W-1:0] len;

    assign len = dbd_pkg::month_len(cur.month, dbd_pkg::is_leap(cur_r400));

    always_comb
    begin
        nxt      = cur;
        nxt_r400 = cur_r400;
        if (cur.day != len)
        begin
            nxt.day = cur.day + 1'b1;
        end
        else
        begin
            nxt.day = 5'd1;
            if (cur.month == dbd_pkg::MONTH_DEC)
            begin
                nxt.month = dbd_pkg::MONTH_JAN;
                nxt.year  = cur.year + 1'b1;
                nxt_r400  = (cur_r400 == dbd_pkg::R400_LAST) ? '0 : cur_r400 + 1'b1;
            end
            else
            begin
                nxt.month = cur.month + 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== sv/days_between_dates_counter.sv =====
// Sequence: take the request, reduce the start and end years modulo 400 in turn with one
// shared subtractor, check both dates, then, if both are valid and the start is earlier,
// walk the date stepper day by day until it reaches the end date or the count saturates,
// and load the result register when it is free.
// Throughput: one request at a time; s_tready is high only while the sequencer is idle.
// Reset (rst_n low, asynchronous) empties the result register and idles the sequencer.
// Depends on dbd_pkg and dbd_step.
`timescale 1ns / 1ps
`default_nettype none

module days_between_dates_counter (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // start_day[4:0], start_month[8:5], start_year[22:9],
    // end_day[27:23], end_month[31:28], end_year[45:32], zero pad[47:46]
    input  logic [47:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // day_count[21:0], zero pad[23:22]
    output logic [23:0] m_tdata,
    // bad_date[0]
    output logic        m_tuser
);

    localparam int YW = dbd_pkg::YEAR_W;
    localparam int RW = dbd_pkg::R400_W;
    localparam int CW = dbd_pkg::COUNT_W;

    dbd_pkg::state_t state_reg, state_next;
    dbd_pkg::date_t  start_reg, start_next;
    dbd_pkg::date_t  end_reg, end_next;
    dbd_pkg::date_t  work_reg, work_next;
    logic [YW-1:0]   rem_reg, rem_next;
    logic [RW-1:0]   start_r400_reg, start_r400_next;
    logic            end_leap_reg, end_leap_next;
    logic [RW-1:0]   work_r400_reg, work_r400_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            bad_reg, bad_next;
    logic [CW-1:0]   out_count_reg, out_count_next;
    logic            out_bad_reg, out_bad_next;
    logic            out_valid_reg, out_valid_next;

    dbd_pkg::date_t  step_date;
    logic [RW-1:0]   step_r400;
    logic [YW-1:0]   rem_diff;
    logic            rem_big;
    logic            start_ok;
    logic            end_ok;
    logic            load_out;
    logic [dbd_pkg::DAY_W-1:0] start_len;
    logic [dbd_pkg::DAY_W-1:0] end_len;

    dbd_step u_step (
        .cur      (work_reg),
        .cur_r400 (work_r400_reg),
        .nxt      (step_date),
        .nxt_r400 (step_r400)
    );

    // The single subtractor that reduces both years modulo 400.
    assign rem_diff = rem_reg - dbd_pkg::YEAR_CYCLE;
    assign rem_big  = (rem_reg >= dbd_pkg::YEAR_CYCLE);

    assign start_len = dbd_pkg::month_len(start_reg.month, dbd_pkg::is_leap(start_r400_reg));
    assign end_len   = dbd_pkg::month_len(end_reg.month, end_leap_reg);
    assign start_ok  = (start_reg.day != '0) && (start_reg.day <= start_len);
    assign end_ok    = (end_reg.day != '0) && (end_reg.day <= end_len);

    assign load_out = (state_reg == dbd_pkg::ST_FINISH) && (!out_valid_reg || m_tready);

    assign s_tready = (state_reg == dbd_pkg::ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_count_reg};
    assign m_tuser  = out_bad_reg;

    always_comb
    begin
        state_next      = state_reg;
        start_next      = start_reg;
        end_next        = end_reg;
        work_next       = work_reg;
        rem_next        = rem_reg;
        start_r400_next = start_r400_reg;
        end_leap_next   = end_leap_reg;
        work_r400_next  = work_r400_reg;
        count_next      = count_reg;
        bad_next        = bad_reg;
        out_count_next  = out_count_reg;
        out_bad_next    = out_bad_reg;
        out_valid_next  = out_valid_reg && !m_tready;

        unique case (state_reg)
            dbd_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    start_next.day   = s_tdata[4:0];
                    start_next.month = s_tdata[8:5];
                    start_next.year  = s_tdata[22:9];
                    end_next.day     = s_tdata[27:23];
                    end_next.month   = s_tdata[31:28];
                    end_next.year    = s_tdata[45:32];
                    rem_next         = s_tdata[22:9];
                    state_next       = dbd_pkg::ST_MOD_START;
                end
            end
            dbd_pkg::ST_MOD_START:
            begin
                if (rem_big)
                begin
                    rem_next = rem_diff;
                end
                else
                begin
                    start_r400_next = rem_reg[RW-1:0];
                    rem_next        = end_reg.year;
                    state_next      = dbd_pkg::ST_MOD_END;
                end
            end
            dbd_pkg::ST_MOD_END:
            begin
                if (rem_big)
                begin
                    rem_next = rem_diff;
                end
                else
                begin
                    end_leap_next = dbd_pkg::is_leap(rem_reg[RW-1:0]);
                    state_next    = dbd_pkg::ST_CHECK;
                end
            end
            dbd_pkg::ST_CHECK:
            begin
                count_next = '0;
                if (!start_ok || !end_ok)
                begin
                    bad_next   = 1'b1;
                    state_next = dbd_pkg::ST_FINISH;
                end
                else
                begin
                    bad_next       = 1'b0;
                    work_next      = start_reg;
                    work_r400_next = start_r400_reg;
                    state_next     = (start_reg < end_reg) ? dbd_pkg::ST_WALK
                                                           : dbd_pkg::ST_FINISH;
                end
            end
            dbd_pkg::ST_WALK:
            begin
                // A saturated count ends the walk early; the answer cannot change.
                if ((work_reg == end_reg) || (count_reg == dbd_pkg::COUNT_MAX))
                begin
                    state_next = dbd_pkg::ST_FINISH;
                end
                else
                begin
                    work_next      = step_date;
                    work_r400_next = step_r400;
                    count_next     = count_reg + 1'b1;
                end
            end
            dbd_pkg::ST_FINISH:
            begin
                if (load_out)
                begin
                    out_count_next = count_reg;
                    out_bad_next   = bad_reg;
                    out_valid_next = 1'b1;
                    state_next     = dbd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = dbd_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= dbd_pkg::ST_IDLE;
            out_valid_reg  <= 1'b0;
            work_reg.day   <= 5'd1;
            work_reg.month <= dbd_pkg::MONTH_JAN;
            work_reg.year  <= 14'd1;
            work_r400_reg  <= 9'd1;
            count_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            work_reg      <= work_next;
            work_r400_reg <= work_r400_next;
            count_reg     <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        start_reg      <= start_next;
        end_reg        <= end_next;
        rem_reg        <= rem_next;
        start_r400_reg <= start_r400_next;
        end_leap_reg   <= end_leap_next;
        bad_reg        <= bad_next;
        out_count_reg  <= out_count_next;
        out_bad_reg    <= out_bad_next;
    end

    a_bad_means_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata[CW-1:0] == '0)
        else $error("bad_date result carries a nonzero day count");

    a_walk_not_past_end: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == dbd_pkg::ST_WALK |-> work_reg <= end_reg)
        else $error("working date moved past the end date");

    a_r400_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == dbd_pkg::ST_WALK |-> work_r400_reg <= dbd_pkg::R400_LAST)
        else $error("year residue left the range of a 400-year cycle");

    a_finish_loads: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> m_tvalid && state_reg == dbd_pkg::ST_IDLE)
        else $error("finished request did not reach the result register");

endmodule

`default_nettype wire
